// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the evaluator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge out of reset.
`define PSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pse: assertion failed");

// Expression must never be true out of reset.
`define PSE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pse: forbidden condition seen");

`else

`define PSE_ASSERT(lbl, clk, rst_n, prop)
`define PSE_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/pse_pkg.sv =====
package pse_pkg;

    // Token codes carried on the input tuser.
    typedef enum logic [2:0] {
        TOK_PUSH = 3'd0,
        TOK_ADD  = 3'd1,
        TOK_SUB  = 3'd2,
        TOK_MUL  = 3'd3,
        TOK_DIV  = 3'd4,
        TOK_END  = 3'd5
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic push;       // write operand at top, count up
        logic fetch;      // read the two top entries
        logic set_err;
        logic arith_wr;   // write add/sub result
        logic is_sub;
        logic mul_start;
        logic div_start;
        logic mul_wr;
        logic div_wr;
        logic finish;     // load output word, empty the stack
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic full;
        logic lt2;
        logic err;
        logic right_zero;
        logic mul_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned MAG_W  = 128;

    localparam logic [DATA_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

    // Magnitude of a two's complement value, as unsigned.
    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (64'd0 - v) : v;
    endfunction

    // Apply sign to a wide magnitude with saturation.
    function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
        logic big_hi;
        big_hi = |mag[MAG_W-1:DATA_W];
        if (neg) begin
            if (big_hi || (mag[DATA_W-1:0] > Q_MIN))
                return Q_MIN;
            return 64'd0 - mag[DATA_W-1:0];
        end
        if (big_hi || (mag[DATA_W-1:0] > Q_MAX))
            return Q_MAX;
        return mag[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/pse_mul.sv =====
module pse_mul
    import pse_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] result
);

    localparam logic [MAG_W-1:0] HALF = (MAG_W'(1) << FRACTION_BITS) >> 1;

    // step 0..3: partial products, 1..4: accumulate, 5: round, 6: saturate
    localparam logic [2:0] STEP_ACC_LAST = 3'd4;
    localparam logic [2:0] STEP_RND      = 3'd5;
    localparam logic [2:0] STEP_SAT      = 3'd6;

    logic              busy_reg;
    logic [2:0]        step_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] pp_reg;
    logic [MAG_W-1:0]  acc_reg;
    logic [MAG_W-1:0]  rnd_reg;
    logic [DATA_W-1:0] res_reg;

    logic [31:0]       xs;
    logic [31:0]       ys;
    logic [DATA_W-1:0] pp_prod;
    logic [6:0]        pp_shift;
    logic              do_acc;

    assign xs = step_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign ys = step_reg[0] ? y_reg[63:32] : y_reg[31:0];
    // full 64-bit product of the two 32-bit halves
    assign pp_prod = xs * ys;
    assign do_acc = busy_reg && (step_reg != 3'd0) && (step_reg <= STEP_ACC_LAST);

    // weight of the product registered in the previous step
    always_comb
    begin
        case (step_reg) inside
            3'd2, 3'd3: pp_shift = 7'd32;
            3'd4:       pp_shift = 7'd64;
            default:    pp_shift = 7'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_SAT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            x_reg   <= mag_of(a);
            y_reg   <= mag_of(b);
            acc_reg <= '0;
        end
        else
        begin
            if (busy_reg && !step_reg[2])
                pp_reg <= pp_prod;
            if (do_acc)
                acc_reg <= acc_reg + (MAG_W'(pp_reg) << pp_shift);
            if (busy_reg && (step_reg == STEP_RND))
                rnd_reg <= (acc_reg + HALF) >> FRACTION_BITS;
            if (busy_reg && (step_reg == STEP_SAT))
                res_reg <= sat_mag(neg_reg, rnd_reg);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/pse_div.sv =====
module pse_div
    import pse_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] result
);

    localparam int NUM_W = DATA_W + FRACTION_BITS;
    localparam int BIT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              sat_phase_reg;
    logic              done_reg;
    logic [BIT_W-1:0]  bits_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] d_reg;
    logic [NUM_W:0]    rnd_reg;
    logic [DATA_W-1:0] res_reg;

    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W:0]   rem_sub;
    logic              round_up;
    logic              iterate;
    logic              round_step;

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, d_reg};
    assign rem_sub  = ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
    // round half away from zero: 2*rem >= divisor
    assign round_up = {rem_reg, 1'b0} >= {1'b0, d_reg};

    assign iterate    = busy_reg && (bits_reg != '0);
    assign round_step = busy_reg && (bits_reg == '0) && !sat_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sat_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
            bits_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg      <= 1'b1;
                sat_phase_reg <= 1'b0;
                bits_reg      <= BIT_W'(NUM_W);
            end
            else if (iterate)
                bits_reg <= bits_reg - BIT_W'(1);
            else if (round_step)
                sat_phase_reg <= 1'b1;
            else if (sat_phase_reg)
            begin
                sat_phase_reg <= 1'b0;
                busy_reg      <= 1'b0;
                done_reg      <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            num_reg <= NUM_W'(mag_of(a)) << FRACTION_BITS;
            d_reg   <= mag_of(b);
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (iterate)
        begin
            num_reg <= num_reg << 1;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= rem_sub[DATA_W-1:0];
        end
        else if (round_step)
            rnd_reg <= {1'b0, q_reg} + (NUM_W + 1)'(round_up);
        else if (sat_phase_reg)
            res_reg <= sat_mag(neg_reg, MAG_W'(rnd_reg));
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/pse_datapath.sv =====
`include "assert_macros.svh"

module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH   = 256,
    parameter int FRACTION_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [DATA_W-1:0] operand,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] out_value,
    output logic              out_error
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_error_reg;
    logic [DATA_W-1:0] rd_right_reg;
    logic [DATA_W-1:0] rd_left_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] addsub;
    logic              ovf;
    logic              bad;
    logic              mul_done, div_done;
    logic [DATA_W-1:0] mul_res, div_res;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);

    // saturating add / subtract, left is the deeper entry
    assign sum  = rd_left_reg + rd_right_reg;
    assign diff = rd_left_reg - rd_right_reg;
    always_comb
    begin
        if (cmd.is_sub)
            ovf = (rd_left_reg[DATA_W-1] ^ rd_right_reg[DATA_W-1])
                & (diff[DATA_W-1] ^ rd_left_reg[DATA_W-1]);
        else
            ovf = ~(rd_left_reg[DATA_W-1] ^ rd_right_reg[DATA_W-1])
                & (sum[DATA_W-1] ^ rd_left_reg[DATA_W-1]);
        if (ovf)
            addsub = rd_left_reg[DATA_W-1] ? Q_MIN : Q_MAX;
        else
            addsub = cmd.is_sub ? diff : sum;
    end

    assign wr_en   = cmd.push | cmd.arith_wr | cmd.mul_wr | cmd.div_wr;
    assign wr_addr = cmd.push ? count_reg[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];

    always_comb
    begin
        if (cmd.push)
            wr_data = operand;
        else if (cmd.mul_wr)
            wr_data = mul_res;
        else if (cmd.div_wr)
            wr_data = div_res;
        else
            wr_data = addsub;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_right_reg <= stack_mem[cnt_m1[ADDR_W-1:0]];
            rd_left_reg  <= stack_mem[cnt_m2[ADDR_W-1:0]];
        end
    end

    assign bad = err_reg || (count_reg != CNT_W'(1));

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.finish)
        begin
            count_next = '0;
            err_next   = 1'b0;
        end
        else
        begin
            if (cmd.push)
                count_next = count_reg + CNT_W'(1);
            else if (cmd.arith_wr || cmd.mul_wr || cmd.div_wr)
                count_next = cnt_m1;
            if (cmd.set_err)
                err_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_value_reg <= bad ? '0 : rd_right_reg;
            out_error_reg <= bad;
        end
    end

    pse_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (rd_left_reg),
        .b      (rd_right_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    pse_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .a      (rd_left_reg),
        .b      (rd_right_reg),
        .done   (div_done),
        .result (div_res)
    );

    assign stat.full       = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.lt2        = (count_reg < CNT_W'(2));
    assign stat.err        = err_reg;
    assign stat.right_zero = (rd_right_reg == '0);
    assign stat.mul_done   = mul_done;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_error = out_error_reg;

    `PSE_ASSERT(a_cnt_range, clk, rst_n, count_reg <= CNT_W'(STACK_DEPTH))
    `PSE_ASSERT(a_push_inc, clk, rst_n, cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
    `PSE_ASSERT(a_finish_clr, clk, rst_n, cmd.finish |=> (count_reg == '0) && !err_reg && out_valid_reg)

endmodule

// ===== rtl/pse_ctrl.sv =====
`include "assert_macros.svh"

module pse_ctrl
    import pse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [2:0] req_type,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    tok_t   op_reg, op_next;
    tok_t   kind;

    assign kind = tok_t'(req_type);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= TOK_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (kind) inside
                        TOK_PUSH:
                            cmd.push = !stat.err && !stat.full;
                        TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV:
                        begin
                            if (!stat.err)
                            begin
                                if (stat.lt2)
                                    cmd.set_err = 1'b1;
                                else
                                begin
                                    cmd.fetch  = 1'b1;
                                    op_next    = kind;
                                    state_next = ST_EXEC;
                                end
                            end
                        end
                        TOK_END:
                        begin
                            cmd.fetch  = 1'b1;
                            op_next    = kind;
                            state_next = ST_EXEC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg) inside
                    TOK_ADD, TOK_SUB:
                    begin
                        cmd.arith_wr = 1'b1;
                        cmd.is_sub   = (op_reg == TOK_SUB);
                        state_next   = ST_IDLE;
                    end
                    TOK_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = ST_MUL;
                    end
                    TOK_DIV:
                    begin
                        if (stat.right_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    TOK_END:
                    begin
                        // hold until the output register can take the word
                        if (stat.out_free)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PSE_ASSERT_NEVER(a_err_in_unit, clk, rst_n, ((state_reg == ST_MUL) || (state_reg == ST_DIV)) && stat.err)
    `PSE_ASSERT(a_one_writer, clk, rst_n, $onehot0({cmd.push, cmd.arith_wr, cmd.mul_wr, cmd.div_wr}))

endmodule

// ===== rtl/postfix_stack_evaluator_top.sv =====
// Channel | Dir | Handshake     | Word contents (low bit up)
// --------+-----+---------------+----------------------------------------------------
// s_*     | in  | tvalid/tready | tdata: operand_value[63:0]; tuser: req_type[2:0]
// m_*     | out | tvalid/tready | tdata: result_value[63:0]; tuser: error_flag[0]
//
// Push, ignored token or operator underflow finish in idle; add/subtract read, then write;
// multiply: four 32x32 partial products, accumulate, round, saturate; divide: one quotient
// bit per cycle (zero divisor sets the error instead); end mark waits for the output.
// One token is in flight at a time; s_tready is high only when idle.
// Reset clears stack count, error, output valid and unit/sequencer state; stack memory needs no clearing pass.
// A finished word waits in the output register; a second end mark waits on it.
module postfix_stack_evaluator_top
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH   = 256,
    parameter int FRACTION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // token input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] operand_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] result_value
    output logic [0:0]  m_tuser    // [0] error_flag
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     out_error;

    // sequencer: decodes tokens, steps through read / execute / unit wait
    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack memory, count, sticky error, arithmetic units, output register
    pse_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operand   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_value (m_tdata),
        .out_error (out_error)
    );

    assign m_tuser[0] = out_error;

endmodule
